[rtl/core/sml_pkg.sv]
// ----------------------------------------------------------------------------
// sml_pkg
// Shared types and constants of the sorted multiset list unit.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int KindW      = 2;
  localparam int ValW       = 32;
  localparam int HeldW      = 6;
  localparam int MaxResults = 32;
  localparam int NumW       = $clog2(MaxResults);

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DUMP = 2'd2
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch kind and value of the accepted beat
    logic exec;        // apply insert / delete and post its result
    logic dump_start;  // arm the dump walker
    logic dump_step;   // one dump walker step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dump_done;   // final dump result loaded into the result register this cycle
  } stat_t;

endpackage

[rtl/core/sml_ctrl.sv]
// ----------------------------------------------------------------------------
// sml_ctrl
// Sequencer: accepts a command beat and steps the datapath through it.
// ----------------------------------------------------------------------------
module sml_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sml_pkg::KindW-1:0]   kind_i,
  input  sml_pkg::stat_t              stat_i,
  output sml_pkg::cmd_t               cmd_o,
  output logic                        busy_o
);

  sml_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sml_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      sml_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          if (kind_i == sml_pkg::KIND_DUMP) begin
            cmd_o.dump_start = 1'b1;
            state_d          = sml_pkg::ST_DUMP;
          end else begin
            state_d = sml_pkg::ST_EXEC;
          end
        end
      end
      sml_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sml_pkg::ST_IDLE;
      end
      sml_pkg::ST_DUMP: begin
        cmd_o.dump_step = 1'b1;
        if (stat_i.dump_done) begin
          state_d = sml_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sml_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/sml_dpath.sv]
// ----------------------------------------------------------------------------
// sml_dpath
// Sorted cell chain with per-cell compare, dump walker and result register.
// ----------------------------------------------------------------------------
module sml_dpath #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sml_pkg::cmd_t                      cmd_i,
  input  logic [sml_pkg::KindW-1:0]          kind_i,
  input  logic signed [sml_pkg::ValW-1:0]    value_i,
  output sml_pkg::stat_t                     stat_o,
  output logic                               out_valid_o,
  output logic signed [sml_pkg::ValW-1:0]    item_o,
  output logic                               item_valid_o,
  output logic [sml_pkg::HeldW-1:0]          held_o,
  output logic                               dropped_o,
  output logic                               last_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int ValW = sml_pkg::ValW;
  localparam int NumW = sml_pkg::NumW;

  logic signed [ValW-1:0] cells_q [CAPACITY];
  logic signed [ValW-1:0] cells_d [CAPACITY];
  logic signed [ValW-1:0] ins_w   [CAPACITY];
  logic signed [ValW-1:0] shl_w   [CAPACITY];
  logic                   cells_we;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [sml_pkg::KindW-1:0] op_q;
  logic signed [ValW-1:0]   val_q;

  logic [CntW-1:0]        rem_q, rem_d;
  logic [NumW-1:0]        num_q, num_d;
  logic signed [ValW-1:0] pend_q, pend_d;
  logic                   pend_v_q, pend_v_d;

  logic                   ov_q, ov_d;
  logic signed [ValW-1:0] item_q, item_d;
  logic                   iv_q, iv_d;
  logic [sml_pkg::HeldW-1:0] held_q, held_d;
  logic                   drop_q, drop_d;
  logic                   last_q, last_d;

  logic [CAPACITY-1:0] le_w;   // occupied and <= operand (prefix, list sorted)
  logic [CAPACITY-1:0] ge_w;   // occupied and >= operand (suffix of occupied part)
  logic [CAPACITY-1:0] eq_w;
  logic                full_w;
  logic                found_w;

  // per-cell compares and neighbor moves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    assign occ     = CntW'(i) < cnt_q;
    assign le_w[i] = occ && (cells_q[i] <= val_q);
    assign ge_w[i] = occ && (cells_q[i] >= val_q);
    assign eq_w[i] = occ && (cells_q[i] == val_q);

    if (i == 0) begin : g_first
      assign ins_w[i] = le_w[i] ? cells_q[i] : val_q;
    end else begin : g_rest
      assign ins_w[i] = le_w[i]   ? cells_q[i] :
                        le_w[i-1] ? val_q      : cells_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign shl_w[i] = cells_q[i];
    end else begin : g_low
      assign shl_w[i] = cells_q[i+1];
    end
  end

  assign full_w  = (cnt_q == CntW'(CAPACITY));
  assign found_w = |eq_w;

  always_comb begin
    cells_d  = cells_q;
    cells_we = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    num_d    = num_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    ov_d     = 1'b0;
    item_d   = '0;
    iv_d     = 1'b0;
    held_d   = sml_pkg::HeldW'(cnt_q);
    drop_d   = 1'b0;
    last_d   = 1'b0;
    stat_o   = '0;

    if (cmd_i.exec) begin
      case (sml_pkg::kind_e'(op_q))
        sml_pkg::KIND_INSERT: begin
          ov_d   = 1'b1;
          last_d = 1'b1;
          if (full_w) begin
            drop_d = 1'b1;
          end else begin
            cells_d  = ins_w;
            cells_we = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
            held_d   = sml_pkg::HeldW'(cnt_q + CntW'(1));
          end
        end
        sml_pkg::KIND_DELETE: begin
          ov_d   = 1'b1;
          last_d = 1'b1;
          if (found_w) begin
            // first equal entry is the first one >= operand; close the gap
            for (int i = 0; i < CAPACITY; i++) begin
              if (ge_w[i]) begin
                cells_d[i] = shl_w[i];
              end
            end
            cells_we = 1'b1;
            cnt_d    = cnt_q - CntW'(1);
            held_d   = sml_pkg::HeldW'(cnt_q - CntW'(1));
          end
        end
        default: begin
          ov_d = 1'b0;
        end
      endcase
    end

    if (cmd_i.dump_start) begin
      rem_d    = cnt_q;
      num_d    = '0;
      pend_v_d = 1'b0;
    end

    // pending value is posted once the next distinct value (or the end) shows up
    if (cmd_i.dump_step) begin
      if (rem_q == '0) begin
        ov_d          = 1'b1;
        item_d        = pend_v_q ? pend_q : '0;
        iv_d          = pend_v_q;
        last_d        = 1'b1;
        stat_o.dump_done = 1'b1;
      end else begin
        cells_d  = shl_w;
        cells_we = 1'b1;
        rem_d    = rem_q - CntW'(1);
        if (!pend_v_q) begin
          pend_d   = cells_q[0];
          pend_v_d = 1'b1;
        end else if (cells_q[0] != pend_q) begin
          ov_d   = 1'b1;
          item_d = pend_q;
          iv_d   = 1'b1;
          pend_d = cells_q[0];
          num_d  = num_q + NumW'(1);
          if (num_q == NumW'(sml_pkg::MaxResults - 1)) begin
            last_d           = 1'b1;
            stat_o.dump_done = 1'b1;
          end
        end
      end
      if (stat_o.dump_done) begin
        cnt_d    = '0;
        pend_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rem_q    <= '0;
      num_q    <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      num_q    <= num_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= kind_i;
      val_q <= value_i;
    end
    if (cells_we) begin
      cells_q <= cells_d;
    end
    pend_q <= pend_d;
    item_q <= item_d;
    iv_q   <= iv_d;
    held_q <= held_d;
    drop_q <= drop_d;
    last_q <= last_d;
  end

  assign out_valid_o  = ov_q;
  assign item_o       = item_q;
  assign item_valid_o = iv_q;
  assign held_o       = held_q;
  assign dropped_o    = drop_q;
  assign last_o       = last_q;

endmodule

[rtl/core/sorted_multiset_list_unit.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_list_unit
// Bounded multiset of signed 32-bit values kept sorted in a register chain.
// ----------------------------------------------------------------------------
// A command beat is taken when start_i is high and busy_o is low. Insert and
// delete capture the beat, then do one parallel compare-and-shift over the
// cell chain; their single result appears in the cycle after that. A dump
// walks the chain one cell per cycle, keeping busy_o high until it ends,
// and posts one result per distinct value (at most 32) as the walk finds
// it; an empty dump posts one result. Every result is shown for exactly
// one cycle with out_valid_o high and cannot be stalled. kind 3 is taken and
// produces no result. The cells have no reset; only the control state, the
// held count, the dump counters, out_valid_o and the pending flag are cleared.
module sorted_multiset_list_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [sml_pkg::KindW-1:0]          kind_i,
  input  logic signed [sml_pkg::ValW-1:0]    value_i,
  output logic                               out_valid_o,
  output logic signed [sml_pkg::ValW-1:0]    item_o,
  output logic                               item_valid_o,
  output logic [sml_pkg::HeldW-1:0]          held_o,
  output logic                               dropped_o,
  output logic                               last_o
);

  sml_pkg::cmd_t  cmd;
  sml_pkg::stat_t stat;

  sml_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  sml_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .item_o      (item_o),
    .item_valid_o(item_valid_o),
    .held_o      (held_o),
    .dropped_o   (dropped_o),
    .last_o      (last_o)
  );

endmodule

[rtl/core/sml_checker.sv]
// ----------------------------------------------------------------------------
// sml_checker
// Port-level checks of the sorted multiset list unit, bound to the top level.
// ----------------------------------------------------------------------------
module sml_checker #(
  parameter int CAPACITY = 32
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               out_valid_o,
  input logic                               item_valid_o,
  input logic [sml_pkg::HeldW-1:0]          held_o,
  input logic                               dropped_o,
  input logic                               last_o
);

  // a taken beat always sets the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("unit not busy after a taken beat");

  a_drop_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> !item_valid_o && last_o)
    else $error("dropped insert posted with an item or without last");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> held_o == sml_pkg::HeldW'(CAPACITY))
    else $error("dropped insert does not report a full store");

  // only dump beats give more than one result
  a_nonlast_is_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> item_valid_o && busy_o)
    else $error("non-final result outside a dump");

endmodule

bind sorted_multiset_list_unit sml_checker #(
  .CAPACITY(CAPACITY)
) u_sml_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .out_valid_o (out_valid_o),
  .item_valid_o(item_valid_o),
  .held_o      (held_o),
  .dropped_o   (dropped_o),
  .last_o      (last_o)
);
